>>> hdl/frr_pkg.sv
// Shared constants, codes and types of the fractional-rate resampler.
package frr_pkg;

   localparam int NUM_CHANNELS   = 32;
   localparam int MAX_OUT_PER_IN = 16;

   localparam int CHAN_W     = 5;
   localparam int SAMPLE_W   = 24;
   localparam int PHASE_W    = 26;
   localparam int PICK_W     = 17;
   localparam int RATE_W     = 24;
   localparam int MODE_W     = 2;
   localparam int ENABLE_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PH_FRAC    = 16;

   localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W = $clog2(MAX_OUT_PER_IN + 1);

   // Datapath widths of the interpolation pipeline.
   localparam int PROD_W = SAMPLE_W + 1 + PICK_W;
   localparam int A2_W   = SAMPLE_W + 2;
   localparam int PP_W   = 2 * PICK_W - 2;
   localparam int AP_W   = A2_W + PP_W;
   localparam int NUM_W  = AP_W + 2;
   localparam int R_W    = SAMPLE_W + 3;
   localparam int SUM_W  = SAMPLE_W + 4;

   localparam logic signed [PHASE_W-1:0] PH_ONE  = PHASE_W'(1 <<< PH_FRAC);
   localparam logic signed [PHASE_W-1:0] PH_HALF = PHASE_W'(1 <<< (PH_FRAC - 1));

   localparam logic signed [SAMPLE_W-1:0] SAMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUAD    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERP_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_STEP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ENABLE = 2'd2;

   localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_NEAREST;
   localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(1 << PH_FRAC);
   localparam logic [ENABLE_W-1:0] ENABLE_RESET = ENABLE_W'(1);

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_LOOKUP,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      logic signed [PHASE_W-1:0]  phase;
      logic signed [SAMPLE_W-1:0] h1;
      logic signed [SAMPLE_W-1:0] h2;
   } chan_state_type;

   typedef struct packed {
      logic [CHAN_W-1:0]          chan;
      logic signed [PICK_W-1:0]   phase;
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] h1;
      logic signed [SAMPLE_W-1:0] h2;
      logic                       last;
   } pick_type;

   typedef struct packed {
      logic [CHAN_W-1:0]          chan;
      logic signed [SAMPLE_W-1:0] value;
      logic                       last;
   } result_type;

endpackage

>>> hdl/frr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/frr_seq.sv
// Per-channel sequencer: state lookup, pick issue and state write-back.
module frr_seq import frr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CHAN_W-1:0]          req_chan,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_restart,
   input  logic [RATE_W-1:0]          rate_step,
   input  logic [ENABLE_W-1:0]        channel_enable,
   input  logic                       advance,
   output logic                       pick_valid,
   output pick_type                   pick
);

   seq_state_type state_ff, state_in;

   logic [CHAN_W-1:0]          chan_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       restart_ff;
   logic                       enabled_ff;
   logic signed [PHASE_W-1:0]  ph_ff;
   logic signed [SAMPLE_W-1:0] h1_ff;
   logic signed [SAMPLE_W-1:0] h2_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [NUM_CHANNELS-1:0]    valid_ff;

   logic                       accept;
   logic                       rd_en;
   logic                       load;
   logic                       issue;
   logic                       wr_en;
   logic                       more;
   logic                       fresh;
   logic                       req_enabled;
   logic [CH_AW-1:0]           addr;
   logic signed [PHASE_W-1:0]  ph_next;
   logic signed [PHASE_W-1:0]  ph_final;
   chan_state_type             rd_data;
   chan_state_type             wr_data;

   assign addr        = chan_ff[CH_AW-1:0];
   assign req_enabled = ({1'b0, req_chan} < (CHAN_W+1)'(NUM_CHANNELS))
                        && channel_enable[req_chan];
   assign more        = (ph_ff < PH_HALF) && (cnt_ff < CNT_W'(MAX_OUT_PER_IN));
   assign ph_next     = ph_ff + $signed({{(PHASE_W-RATE_W){1'b0}}, rate_step});
   assign ph_final    = ((ph_ff < PH_HALF) ? PH_HALF : ph_ff) - PH_ONE;
   assign fresh       = restart_ff || !valid_ff[addr];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               state_in = SEQ_LOOKUP;
            end
         end
         SEQ_LOOKUP: begin
            state_in = enabled_ff ? SEQ_RUN : SEQ_IDLE;
         end
         SEQ_RUN: begin
            if (!more) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      load      = 1'b0;
      issue     = 1'b0;
      wr_en     = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
         end
         SEQ_LOOKUP: begin
            load = enabled_ff;
         end
         SEQ_RUN: begin
            issue = more && advance;
            wr_en = !more;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;
   assign rd_en  = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff    <= req_chan;
         x_ff       <= req_sample_in;
         restart_ff <= req_restart;
         enabled_ff <= req_enabled;
      end
      if (load) begin
         ph_ff  <= fresh ? '0 : rd_data.phase;
         h1_ff  <= fresh ? '0 : rd_data.h1;
         h2_ff  <= fresh ? '0 : rd_data.h2;
         cnt_ff <= '0;
      end else if (issue) begin
         ph_ff  <= ph_next;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign wr_data.phase = ph_final;
   assign wr_data.h1    = x_ff;
   assign wr_data.h2    = h1_ff;

   frr_ram #(
      .WIDTH ($bits(chan_state_type)),
      .DEPTH (NUM_CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (req_chan[CH_AW-1:0]),
      .rd_data (rd_data)
   );

   assign pick_valid = issue;
   assign pick.chan  = chan_ff;
   assign pick.phase = $signed(ph_ff[PICK_W-1:0]);
   assign pick.x     = x_ff;
   assign pick.h1    = h1_ff;
   assign pick.h2    = h2_ff;
   assign pick.last  = (ph_next >= PH_HALF) || (cnt_ff == CNT_W'(MAX_OUT_PER_IN - 1));

`ifndef SYNTH
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("state RAM read and write in the same cycle");

   a_pick_phase_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> (ph_ff >= -PH_HALF) && (ph_ff < PH_HALF))
      else $error("issued pick phase outside of one half around the sample");

   a_last_then_write: assert property (@(posedge clock) disable iff (reset)
      (issue && pick.last) |=> wr_en)
      else $error("final pick not followed by state write-back");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RUN) |-> (cnt_ff <= CNT_W'(MAX_OUT_PER_IN)))
      else $error("pick count above the per-sample limit");
`endif

endmodule

>>> hdl/frr_interp.sv
// Three-stage interpolation pipeline: products, quadratic term, rounding and saturation.
module frr_interp import frr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [MODE_W-1:0] interp_mode,
   input  logic              pick_valid,
   input  pick_type          pick,
   output logic              res_valid,
   output result_type        result
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;

   // Stage 1 registers.
   logic signed [PP_W-1:0]     pp_ff;
   logic signed [PROD_W-1:0]   bp1_ff;
   logic signed [PROD_W-1:0]   dp1_ff;
   logic signed [A2_W-1:0]     a2_ff;
   logic signed [SAMPLE_W-1:0] h1_1_ff, x1_ff;
   logic [CHAN_W-1:0]          chan1_ff;
   logic                       last1_ff;

   // Stage 2 registers.
   logic signed [AP_W-1:0]     ap_ff;
   logic signed [PROD_W-1:0]   bp2_ff;
   logic signed [PROD_W-1:0]   dp2_ff;
   logic signed [SAMPLE_W-1:0] h1_2_ff, x2_ff;
   logic [CHAN_W-1:0]          chan2_ff;
   logic                       last2_ff;

   // Stage 3 registers.
   logic signed [R_W-1:0]      r_ff;
   logic signed [SAMPLE_W-1:0] h1_3_ff, x3_ff;
   logic [CHAN_W-1:0]          chan3_ff;
   logic                       last3_ff;

   logic signed [SAMPLE_W:0]   d_w;
   logic signed [SAMPLE_W:0]   b2_w;
   logic signed [A2_W-1:0]     a2_w;
   logic signed [2*PICK_W-1:0] pp_w;
   logic signed [PROD_W-1:0]   bp_w;
   logic signed [PROD_W-1:0]   dp_w;
   logic signed [NUM_W-1:0]    num_q;
   logic signed [PROD_W-1:0]   num_l;
   logic signed [R_W-1:0]      r_in;
   logic signed [SUM_W-1:0]    sum_w;
   logic signed [SAMPLE_W-1:0] sat_w;

   assign d_w  = (SAMPLE_W+1)'(pick.x) - (SAMPLE_W+1)'(pick.h1);
   assign b2_w = (SAMPLE_W+1)'(pick.x) - (SAMPLE_W+1)'(pick.h2);
   assign a2_w = A2_W'(pick.h2) + A2_W'(pick.x) - (A2_W'(pick.h1) <<< 1);
   assign pp_w = (2*PICK_W)'(pick.phase) * (2*PICK_W)'(pick.phase);
   assign bp_w = PROD_W'(b2_w) * PROD_W'(pick.phase);
   assign dp_w = PROD_W'(d_w) * PROD_W'(pick.phase);

   // The phase square never exceeds 2^30, so the top two product bits are sign copies.
   always_ff @(posedge clock) begin
      if (advance) begin
         pp_ff    <= $signed(pp_w[PP_W-1:0]);
         bp1_ff   <= bp_w;
         dp1_ff   <= dp_w;
         a2_ff    <= a2_w;
         h1_1_ff  <= pick.h1;
         x1_ff    <= pick.x;
         chan1_ff <= pick.chan;
         last1_ff <= pick.last;

         ap_ff    <= AP_W'(a2_ff) * AP_W'(pp_ff);
         bp2_ff   <= bp1_ff;
         dp2_ff   <= dp1_ff;
         h1_2_ff  <= h1_1_ff;
         x2_ff    <= x1_ff;
         chan2_ff <= chan1_ff;
         last2_ff <= last1_ff;

         r_ff     <= r_in;
         h1_3_ff  <= h1_2_ff;
         x3_ff    <= x2_ff;
         chan3_ff <= chan2_ff;
         last3_ff <= last2_ff;
      end
   end

   // Round to nearest, ties upward, by adding half an LSB before a floor shift.
   assign num_q = NUM_W'(ap_ff) + (NUM_W'(bp2_ff) <<< PH_FRAC)
                  + (NUM_W'(1) <<< (2 * PH_FRAC));
   assign num_l = dp2_ff + (PROD_W'(1) <<< (PH_FRAC - 1));

   always_comb begin
      case (interp_mode)
         MODE_NEAREST: r_in = '0;
         MODE_LINEAR:  r_in = R_W'(num_l >>> PH_FRAC);
         MODE_QUAD:    r_in = R_W'(num_q >>> (2 * PH_FRAC + 1));
         default:      r_in = R_W'(num_q >>> (2 * PH_FRAC + 1));
      endcase
   end

   assign sum_w = SUM_W'(h1_3_ff) + SUM_W'(r_ff);

   always_comb begin
      if (sum_w > SUM_W'(SAMP_MAX)) begin
         sat_w = SAMP_MAX;
      end else if (sum_w < SUM_W'(SAMP_MIN)) begin
         sat_w = SAMP_MIN;
      end else begin
         sat_w = SAMPLE_W'(sum_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pick_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   assign res_valid    = s3_valid_ff;
   assign result.chan  = chan3_ff;
   assign result.value = (interp_mode == MODE_NEAREST) ? x3_ff : sat_w;
   assign result.last  = last3_ff;

endmodule

>>> hdl/fractional_rate_resampler.sv
// Top level of the fractional-rate resampler: registers, sequencer, pipeline, output register.
//
//   Port group  Direction  Handshake             Word
//   req_*       in         req_valid/req_ready   chan, sample_in, restart
//   rsp_*       out        rsp_valid/rsp_ready   out_chan, sample_out, last
//   csr_*       in         csr_valid/csr_ready   index, wdata
//
// A sample word holds the input through accept, state RAM read, one issue per output word
// (n of them, 0 to 16) and write-back; a disabled channel ends after the state RAM read.
// Each output word reaches the rsp_* ports through three stages and the output register.
// Reset is synchronous and clears control state and per-channel valid bits; a channel whose
// valid bit is clear reads as zero phase and zero history. While a word waits on rsp_ready
// the pipeline freezes and the sequencer holds its next pick.
module fractional_rate_resampler import frr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CHAN_W-1:0]          req_chan,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_restart,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [CHAN_W-1:0]          rsp_out_chan,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_last,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers: the user writes only while the block is quiet (not enforced).
   logic [MODE_W-1:0]   mode_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic [ENABLE_W-1:0] enable_ff;

   // Output register in front of the result channel.
   logic                       rsp_valid_ff;
   logic [CHAN_W-1:0]          out_chan_ff;
   logic signed [SAMPLE_W-1:0] sample_out_ff;
   logic                       last_ff;

   logic       advance;
   logic       pick_valid;
   pick_type   pick;
   logic       res_valid;
   result_type result;

   // Every stage moves when the output register is empty or being emptied.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         rate_ff   <= RATE_RESET;
         enable_ff <= ENABLE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INTERP_MODE:    mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_RATE_STEP:      rate_ff   <= csr_wdata[RATE_W-1:0];
            CSR_CHANNEL_ENABLE: enable_ff <= csr_wdata[ENABLE_W-1:0];
            default: begin
               mode_ff <= mode_ff;
            end
         endcase
      end
   end

   // The sequencer owns the per-channel state RAM and issues one pick per cycle unless stalled.
   frr_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_chan       (req_chan),
      .req_sample_in  (req_sample_in),
      .req_restart    (req_restart),
      .rate_step      (rate_ff),
      .channel_enable (enable_ff),
      .advance        (advance),
      .pick_valid     (pick_valid),
      .pick           (pick)
   );

   // Interpolation arithmetic, registered after every multiplier.
   frr_interp u_interp (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .interp_mode (mode_ff),
      .pick_valid  (pick_valid),
      .pick        (pick),
      .res_valid   (res_valid),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_chan_ff   <= result.chan;
         sample_out_ff <= result.value;
         last_ff       <= result.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_chan   = out_chan_ff;
   assign rsp_sample_out = sample_out_ff;
   assign rsp_last       = last_ff;

endmodule
